[rtl/core/xosh256_pkg.sv]
// Package for the xoshiro256 generator: opcodes, jump polynomials and the step function.
package xosh256_pkg;

    localparam int WORD_W  = 64;
    localparam int NWORDS  = 4;
    localparam int FRAC_W  = 53;
    localparam int FRAC_SH = WORD_W - FRAC_W;
    localparam int JCNT_W  = 8;

    localparam logic [2:0] OP_NEXT      = 3'd0;
    localparam logic [2:0] OP_JUMP      = 3'd1;
    localparam logic [2:0] OP_LONG_JUMP = 3'd2;
    localparam logic [2:0] OP_WRITE     = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;

    typedef logic [NWORDS-1:0][WORD_W-1:0] t_words;

    // Element 0 is the lowest-order word of the polynomial.
    localparam t_words JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam t_words LONG_JUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    function automatic logic [WORD_W-1:0] f_rotl23(input logic [WORD_W-1:0] x);
        f_rotl23 = {x[WORD_W-24:0], x[WORD_W-1:WORD_W-23]};
    endfunction

    // One generator step.
    function automatic t_words f_advance(input t_words s);
        t_words r;
        logic [WORD_W-1:0] t;
        t    = {s[1][WORD_W-18:0], 17'd0};
        r    = s;
        r[2] = r[2] ^ r[0];
        r[3] = r[3] ^ r[1];
        r[1] = r[1] ^ r[2];
        r[0] = r[0] ^ r[3];
        r[2] = r[2] ^ t;
        r[3] = {r[3][WORD_W-46:0], r[3][WORD_W-1:WORD_W-45]};
        f_advance = r;
    endfunction

    // Polynomial bit for a jump step.
    function automatic logic f_poly_bit(input logic is_long, input logic [JCNT_W-1:0] cnt);
        t_words p;
        p = is_long ? LONG_JUMP_POLY : JUMP_POLY;
        f_poly_bit = p[cnt[7:6]][cnt[5:0]];
    endfunction

endpackage

[rtl/core/xoshiro256_generator_with_jump_unit.sv]
// Top level: xoshiro256 generator with next, jump, long jump, word write and word read.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: an opcode, a word index
//   and a word value. Output channel (o_out_valid / i_out_ready) returns exactly one
//   result item per input item: the scrambled output on next, the state word on read,
//   zero otherwise, plus the top 53 bits of that value as a unit fraction.
//   Items are handled one at a time. An item is taken in the idle state and passes to
//   the finish state, which loads the result into the output register and returns to
//   idle; next, write and read go straight there, so a new item is taken only after
//   the last one's result is loaded. Jump and long jump first run the step unit once
//   per polynomial bit, over all 256 bits, and then go to the finish state.
//   The one-entry output register parts the two sides: the block accepts the next
//   item while an earlier result still waits; only when a second result is ready and
//   the first has not been taken does the sequencer hold in its finish state.
//   i_cfg_we writes the scrambler mode (0 plus, 1 plusplus); write it only while idle.
//   Reset (synchronous, active low) clears the generator words, the jump accumulator,
//   the counter and the mode; the generator outputs zero until its words are loaded.
module xoshiro256_generator_with_jump_unit
    import xosh256_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_opcode,
    input  logic [1:0]        i_word_index,
    input  logic [WORD_W-1:0] i_word_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_result_value,
    output logic [FRAC_W-1:0] o_unit_fraction
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_JUMP = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        r_state, n_state;
    t_words            r_words, n_words;
    t_words            r_accum, n_accum;
    logic [JCNT_W-1:0] r_jcnt, n_jcnt;
    logic              r_long, n_long;
    logic [WORD_W-1:0] r_sum, n_sum;      // pending result before scrambling
    logic [WORD_W-1:0] r_s0, n_s0;        // word 0 before the step, for plusplus
    logic              r_is_next, n_is_next;
    logic [WORD_W-1:0] r_res, n_res;
    logic              r_out_valid, n_out_valid;
    logic              r_mode;

    logic              in_acc;
    logic              poly_bit;
    t_words            acc_x;

    assign o_in_ready      = (r_state == ST_IDLE);
    assign in_acc          = i_in_valid && o_in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_res;
    assign o_unit_fraction = r_res[WORD_W-1:FRAC_SH];

    // Jump step: fold the current words into the accumulator where the polynomial has a one.
    assign poly_bit = f_poly_bit(r_long, r_jcnt);
    assign acc_x    = poly_bit ? (r_accum ^ r_words) : r_accum;

    always_comb begin
        n_state     = r_state;
        n_words     = r_words;
        n_accum     = r_accum;
        n_jcnt      = r_jcnt;
        n_long      = r_long;
        n_sum       = r_sum;
        n_s0        = r_s0;
        n_is_next   = r_is_next;
        n_res       = r_res;
        n_out_valid = r_out_valid;

        // Drop the held result once taken.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_sum     = '0;
                    n_is_next = 1'b0;
                    n_s0      = r_words[0];
                    n_state   = ST_FIN;
                    case (i_opcode)
                        OP_NEXT: begin
                            n_sum     = r_words[0] + r_words[3];
                            n_is_next = 1'b1;
                            n_words   = f_advance(r_words);
                        end
                        OP_JUMP, OP_LONG_JUMP: begin
                            n_long  = (i_opcode == OP_LONG_JUMP);
                            n_accum = '0;
                            n_jcnt  = '0;
                            n_state = ST_JUMP;
                        end
                        OP_WRITE: begin
                            n_words[i_word_index] = i_word_value;
                        end
                        OP_READ: begin
                            n_sum = r_words[i_word_index];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_JUMP: begin
                n_accum = acc_x;
                n_words = f_advance(r_words);
                n_jcnt  = r_jcnt + 1'b1;
                // Last polynomial bit: the accumulator becomes the new state.
                if (r_jcnt == {JCNT_W{1'b1}}) begin
                    n_words = acc_x;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hold here while the output register is still full.
                if (!r_out_valid || i_out_ready) begin
                    n_res       = (r_is_next && r_mode) ? (f_rotl23(r_sum) + r_s0) : r_sum;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_words     <= '0;
            r_accum     <= '0;
            r_jcnt      <= '0;
            r_long      <= 1'b0;
            r_is_next   <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_words     <= n_words;
            r_accum     <= n_accum;
            r_jcnt      <= n_jcnt;
            r_long      <= n_long;
            r_is_next   <= n_is_next;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        r_s0  <= n_s0;
        r_res <= n_res;
    end

    // A jump item enters the step loop on the next cycle.
    a_jump_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_opcode == OP_JUMP || i_opcode == OP_LONG_JUMP)) |=> (r_state == ST_JUMP))
        else $error("jump item did not start the step loop");

    // The bit counter is parked at zero outside the step loop.
    a_jcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_JUMP) |-> (r_jcnt == '0))
        else $error("jump counter not zero outside jump");

    // A write to word 0 lands on the next cycle.
    a_write_w0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode == OP_WRITE && i_word_index == 2'd0)
            |=> (r_words[0] == $past(i_word_value)))
        else $error("state word write lost");

    // A stalled full output keeps the finished result waiting in the finish state.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_out_valid && !i_out_ready) |=> (r_state == ST_FIN))
        else $error("result overwrote an untaken item");

endmodule

[verif/xoshiro256_generator_with_jump_checker.sv]
// Checker for the xoshiro256 generator: predicts each result and compares it with the output.
`timescale 1ns / 100ps
module xoshiro256_generator_with_jump_checker
    import xosh256_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [2:0]        i_opcode,
    input  logic [1:0]        i_word_index,
    input  logic [WORD_W-1:0] i_word_value,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_result_value,
    input  logic [FRAC_W-1:0] i_unit_fraction,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [FRAC_W-1:0] frac;
    } t_gen_result;

    // Bit b of a tap vector is bit b%64 of word b/64 of the jump polynomial.
    localparam logic [255:0] SHORT_TAPS = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] LONG_TAPS = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    logic [WORD_W-1:0] gen_w [NWORDS];
    logic              plusplus = 1'b0;
    t_gen_result       expected_q [$];
    int                n_bad = 0;
    int                n_checked = 0;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

    task automatic step_once();
        logic [WORD_W-1:0] t;
        t = gen_w[1] << 17;
        gen_w[2] ^= gen_w[0];
        gen_w[3] ^= gen_w[1];
        gen_w[1] ^= gen_w[2];
        gen_w[0] ^= gen_w[3];
        gen_w[2] ^= t;
        gen_w[3] = rotl(gen_w[3], 45);
    endtask

    task automatic jump_by(input logic [255:0] taps);
        logic [WORD_W-1:0] acc [NWORDS];
        acc = '{default: '0};
        for (int b = 0; b < 256; b++) begin
            if (taps[b]) begin
                for (int w = 0; w < NWORDS; w++) acc[w] ^= gen_w[w];
            end
            step_once();
        end
        gen_w = acc;
    endtask

    task automatic predict_result(input logic [2:0] op, input logic [1:0] idx,
                                  input logic [WORD_W-1:0] val, output t_gen_result r);
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] sum;
        v = '0;
        case (op)
            OP_NEXT: begin
                sum = gen_w[0] + gen_w[3];
                v = plusplus ? rotl(sum, 23) + gen_w[0] : sum;
                step_once();
            end
            OP_JUMP:      jump_by(SHORT_TAPS);
            OP_LONG_JUMP: jump_by(LONG_TAPS);
            OP_WRITE:     gen_w[idx] = val;
            OP_READ:      v = gen_w[idx];
            default:      ;
        endcase
        r.value = v;
        r.frac  = FRAC_W'(v >> FRAC_SH);
    endtask

    task automatic report(input string what, input logic [WORD_W-1:0] want_v,
                          input logic [WORD_W-1:0] got_v);
        if (n_bad < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want_v, got_v);
        n_bad++;
    endtask

    always @(posedge i_clk) begin
        t_gen_result want;
        if (!i_rst_n) begin
            gen_w = '{default: '0};
            plusplus = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) plusplus = i_cfg_wdata;
            // Retire before predicting: a result never belongs to an item taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result, value", '0, i_result_value);
                end else begin
                    want = expected_q.pop_front();
                    n_checked++;
                    if (want.value !== i_result_value)
                        report("result_value", want.value, i_result_value);
                    if (want.frac !== i_unit_fraction)
                        report("unit_fraction", WORD_W'(want.frac), WORD_W'(i_unit_fraction));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_result(i_opcode, i_word_index, i_word_value, want);
                expected_q.push_back(want);
            end
        end
        o_fail_count <= n_bad;
        o_pending    <= expected_q.size();
        o_checked    <= n_checked;
    end

endmodule

[verif/xoshiro256_generator_with_jump_unit_tb.sv]
// Testbench top for the xoshiro256 generator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module xoshiro256_generator_with_jump_unit_tb;
    import xosh256_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES       = 4;
    localparam int SETTLE       = 8;
    // A jump holds the block while it steps through every polynomial bit; allow for far more jumps than the mix makes.
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    localparam logic [WORD_W-1:0] TOP_BIT  = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} t_rx_style;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [2:0]        i_opcode = OP_NEXT;
    logic [1:0]        i_word_index = '0;
    logic [WORD_W-1:0] i_word_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_result_value;
    logic [FRAC_W-1:0] o_unit_fraction;

    int fail_count;
    int pending_items;
    int checked_items;

    int cycle_count = 0;
    int burst_left = 0;
    int n_next = 0, n_jump = 0, n_word = 0, n_unused = 0;

    t_rx_style rx_style = RX_OPEN;
    int        rx_left = 0;
    int        rx_hold = 0;

    always #5 i_clk = ~i_clk;

    xoshiro256_generator_with_jump_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_unit_fraction(o_unit_fraction)
    );

    xoshiro256_generator_with_jump_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_value (o_result_value),
        .i_unit_fraction(o_unit_fraction),
        .o_fail_count   (fail_count),
        .o_pending      (pending_items),
        .o_checked      (checked_items)
    );

    // Watchdog: end the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                     pending_items);
            $display("[xoshiro256_generator_with_jump_unit] ERROR");
            $finish;
        end
    end

    // Result side: switch between always ready, mostly-ready random and long stall runs,
    // each style held for a random stretch so stalls land on every phase of a jump.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 2));
            rx_left  <= $urandom_range(50, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN: begin
                i_out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                i_out_ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                if (rx_hold != 0) begin
                    i_out_ready <= 1'b0;
                    rx_hold     <= rx_hold - 1;
                end else begin
                    i_out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Present one item and hold it until the block takes it. Returns in the step of
    // the accepting edge with valid still high, so a back-to-back item just reloads.
    task automatic send_op(input logic [2:0] op, input logic [1:0] idx,
                           input logic [WORD_W-1:0] val);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_word_index <= idx;
        i_word_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        case (op)
            OP_NEXT:               n_next++;
            OP_JUMP, OP_LONG_JUMP: n_jump++;
            OP_WRITE, OP_READ:     n_word++;
            default:               n_unused++;
        endcase
    endtask

    // Sender pacing: random-length bursts, then a random gap (sometimes none).
    task automatic issue(input logic [2:0] op, input logic [1:0] idx,
                         input logic [WORD_W-1:0] val);
        int gap;
        send_op(op, idx, val);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_items != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the scrambler mode; only called with the block idle.
    task automatic set_mode(input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random mix: mostly draws, word traffic, rare jumps and some unused opcodes.
    // Every field carries random bits even where the opcode ignores it.
    task automatic random_item();
        int                pick;
        int                shape;
        logic [2:0]        op;
        logic [WORD_W-1:0] val;
        pick = $urandom_range(0, 99);
        val  = {$urandom, $urandom};
        if (pick < 55) begin
            op = OP_NEXT;
        end else if (pick < 70) begin
            op = OP_WRITE;
            shape = $urandom_range(0, 7);
            if (shape == 0) val = '0;
            else if (shape == 1) val = ALL_ONES;
        end else if (pick < 85) begin
            op = OP_READ;
        end else if (pick < 88) begin
            op = OP_JUMP;
        end else if (pick < 90) begin
            op = OP_LONG_JUMP;
        end else begin
            op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        end
        issue(op, 2'($urandom_range(0, 3)), val);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Right after reset the state is all zero: draws and reads return zero.
        issue(OP_NEXT, 2'd0, ALL_ONES);
        issue(OP_READ, 2'd3, '0);

        // Load extreme words; s0+s3 wraps past 2^64 on the first draw.
        issue(OP_WRITE, 2'd0, ALL_ONES);
        issue(OP_WRITE, 2'd1, 64'd1);
        issue(OP_WRITE, 2'd2, TOP_BIT);
        issue(OP_WRITE, 2'd3, ALL_ONES);
        for (int w = 0; w < NWORDS; w++) issue(OP_READ, 2'(w), '0);

        repeat (3) issue(OP_NEXT, 2'd0, '0);

        // Both jumps, each followed by a read and a draw from the jumped state.
        issue(OP_JUMP, 2'd3, ALL_ONES);
        issue(OP_READ, 2'd0, '0);
        issue(OP_NEXT, 2'd0, '0);
        issue(OP_LONG_JUMP, 2'd0, '0);
        issue(OP_READ, 2'd3, '0);
        issue(OP_NEXT, 2'd0, '0);

        // Unused opcodes leave the state alone and answer zero.
        for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
            issue(3'(op), 2'd3, ALL_ONES);

        issue(OP_WRITE, 2'd2, '0);
        issue(OP_NEXT, 2'd0, '0);
        drain();

        // Random phases alternate the scrambler: plusplus, plus, plusplus, plus.
        for (int phase = 0; phase < PHASES; phase++) begin
            set_mode((phase % 2) == 0);
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) random_item();
            drain();
        end

        $display("Sent %0d items: %0d draws, %0d jumps, %0d word writes/reads, %0d unused opcodes",
                 n_next + n_jump + n_word + n_unused, n_next, n_jump, n_word, n_unused);
        $display("Compared %0d results in both scrambler modes under input gaps and output stalls",
                 checked_items);
        if (fail_count == 0 && pending_items == 0) begin
            $display("[xoshiro256_generator_with_jump_unit] OK");
        end else begin
            $display("[xoshiro256_generator_with_jump_unit] ERROR");
        end
        $finish;
    end

endmodule
